// ===== sv/dbdtq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbdtq_pkg
// Shared types and constants for the double-buffered dirty tile queue.
// ----------------------------------------------------------------------------
package dbdtq_pkg;

  // Default list capacity
  localparam int LIST_DEPTH_DEF = 32;

  // Input mode codes
  localparam logic MODE_ENQ   = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_MERGED  = 3'd1,
    ST_DROPPED = 3'd2,
    ST_DRAINED = 3'd3,
    ST_NONE    = 3'd4
  } status_t;

  // One list entry
  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
    logic       p0;
    logic       p1;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture input transaction, restart scan
    logic rd;          // read entry at scan index
    logic enq_merge;   // rewrite matching entry, report merged
    logic enq_next;    // no match at this entry, advance
    logic enq_finish;  // append or drop, report
    logic drn_step;    // process one entry of a drain
    logic drn_finish;  // report last drained tile or nothing pending
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
    logic match;       // entry read matches requested tile
    logic hit_busy;    // drain hit while an earlier tile is still held
    logic last_idx;    // scan index is at the last listed entry
    logic count_zero;  // list is empty
    logic req_mode;    // mode of the current transaction
  } stat_t;

endpackage

// ===== sv/dbdtq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbdtq_ctrl
// Sequencer for the dirty tile queue: walks the list one entry at a time.
// ----------------------------------------------------------------------------
module dbdtq_ctrl
  import dbdtq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = stat.count_zero ? S_FINISH : S_READ;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.req_mode == MODE_ENQ) begin
          if (stat.match) begin
            if (stat.out_free) begin
              cmd.enq_merge = 1'b1;
              state_next    = S_IDLE;
            end
          end else begin
            cmd.enq_next = 1'b1;
            state_next   = stat.last_idx ? S_FINISH : S_READ;
          end
        end else begin
          // a second hit must wait until the held tile can be sent
          if (!stat.hit_busy || stat.out_free) begin
            cmd.drn_step = 1'b1;
            state_next   = stat.last_idx ? S_FINISH : S_READ;
          end
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          if (stat.req_mode == MODE_ENQ) begin
            cmd.enq_finish = 1'b1;
          end else begin
            cmd.drn_finish = 1'b1;
          end
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/dbdtq_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbdtq_dp
// Datapath: entry memory, scan counters, held drain tile and output register.
// ----------------------------------------------------------------------------
module dbdtq_dp
  import dbdtq_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output stat_t      stat,
  input  logic       mode,
  input  logic [7:0] tile_row,
  input  logic [7:0] tile_col,
  input  logic       buffer_sel,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_row,
  output logic [7:0] out_col,
  output logic [2:0] status,
  output logic       last_flag
);

  localparam int ADDR_W = $clog2(LIST_DEPTH);
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);

  // Entry memory
  entry_t mem [LIST_DEPTH];
  entry_t rdata;

  // Scan and list state
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  kept;
  logic [ADDR_W-1:0] idx;

  // Captured transaction
  logic       req_mode;
  logic [7:0] req_row;
  logic [7:0] req_col;
  logic       req_buf;

  // Drain tile waiting to learn whether it is the last
  logic       held_valid;
  logic [7:0] held_row;
  logic [7:0] held_col;

  logic full;
  logic hit;
  logic np0;
  logic np1;
  logic keep;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  entry_t            wdata;

  logic       emit;
  logic [7:0] e_row;
  logic [7:0] e_col;
  status_t    e_st;
  logic       e_last;

  assign full = (count == CNT_W'(LIST_DEPTH));
  assign hit  = req_buf ? rdata.p1 : rdata.p0;
  assign np0  = rdata.p0 & ~(hit & ~req_buf);
  assign np1  = rdata.p1 & ~(hit & req_buf);
  assign keep = np0 | np1;

  // Status to controller
  always_comb begin
    stat.out_free   = ~out_valid | out_ready;
    stat.match      = (rdata.row == req_row) && (rdata.col == req_col);
    stat.hit_busy   = hit & held_valid;
    stat.last_idx   = ((CNT_W'(idx) + CNT_W'(1)) == count);
    stat.count_zero = (count == '0);
    stat.req_mode   = req_mode;
  end

  // Memory write select
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = '{row: req_row, col: req_col, p0: 1'b1, p1: 1'b1};
    priority if (cmd.enq_merge) begin
      we = 1'b1;
    end else if (cmd.enq_finish && !full) begin
      we    = 1'b1;
      waddr = count[ADDR_W-1:0];
    end else if (cmd.drn_step && keep) begin
      we    = 1'b1;
      waddr = kept[ADDR_W-1:0];
      wdata = '{row: rdata.row, col: rdata.col, p0: np0, p1: np1};
    end else begin
      we = 1'b0;
    end
  end

  // Memory port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[idx];
    end
  end

  // Result select
  always_comb begin
    emit   = 1'b0;
    e_row  = req_row;
    e_col  = req_col;
    e_st   = ST_ADDED;
    e_last = 1'b1;
    priority if (cmd.enq_merge) begin
      emit = 1'b1;
      e_st = ST_MERGED;
    end else if (cmd.enq_finish) begin
      emit = 1'b1;
      e_st = full ? ST_DROPPED : ST_ADDED;
    end else if (cmd.drn_step && hit && held_valid) begin
      emit   = 1'b1;
      e_row  = held_row;
      e_col  = held_col;
      e_st   = ST_DRAINED;
      e_last = 1'b0;
    end else if (cmd.drn_finish) begin
      emit = 1'b1;
      if (held_valid) begin
        e_row = held_row;
        e_col = held_col;
        e_st  = ST_DRAINED;
      end else begin
        e_row = 8'd0;
        e_col = 8'd0;
        e_st  = ST_NONE;
      end
    end else begin
      emit = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        held_valid <= 1'b0;
      end
      if (cmd.drn_step && hit) begin
        held_valid <= 1'b1;
      end
      if (cmd.enq_finish && !full) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.drn_finish) begin
        count <= kept;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode <= mode;
      req_row  <= tile_row;
      req_col  <= tile_col;
      req_buf  <= buffer_sel;
      idx      <= '0;
      kept     <= '0;
    end
    if (cmd.enq_next || cmd.drn_step) begin
      idx <= idx + ADDR_W'(1);
    end
    if (cmd.drn_step && keep) begin
      kept <= kept + CNT_W'(1);
    end
    if (cmd.drn_step && hit) begin
      held_row <= rdata.row;
      held_col <= rdata.col;
    end
    if (emit) begin
      out_row   <= e_row;
      out_col   <= e_col;
      status    <= e_st;
      last_flag <= e_last;
    end
  end

endmodule

// ===== sv/double_buffer_dirty_tile_queue.sv =====
`timescale 1ns / 1ps
// Operation: each listed entry is read into a register and then checked; an enqueue
//   stops at the first matching entry, a drain walks the list, and a finish step
//   follows unless an enqueue merges. One item is taken at a time: a new input is
//   accepted only when idle, and a result stalled at the output holds the flow.
// Reset: synchronous; empties the list and clears control and output valid.
//   The entry memory is not cleared; only entries below the count are read.
// ----------------------------------------------------------------------------
// double_buffer_dirty_tile_queue
// Deduplicated dirty tile list with one pending mark per frame buffer.
// ----------------------------------------------------------------------------
module double_buffer_dirty_tile_queue
  import dbdtq_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       mode,
  input  logic [7:0] tile_row,
  input  logic [7:0] tile_col,
  input  logic       buffer_sel,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_row,
  output logic [7:0] out_col,
  output logic [2:0] status,
  output logic       last_flag
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer
  dbdtq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath
  dbdtq_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .mode       (mode),
    .tile_row   (tile_row),
    .tile_col   (tile_col),
    .buffer_sel (buffer_sel),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_row    (out_row),
    .out_col    (out_col),
    .status     (status),
    .last_flag  (last_flag)
  );

endmodule

// ===== sv/dbdtq_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbdtq_chk
// Port-level checks for the dirty tile queue, bound to the top level.
// ----------------------------------------------------------------------------
module dbdtq_chk
  import dbdtq_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       mode,
  input logic [7:0] tile_row,
  input logic [7:0] tile_col,
  input logic       buffer_sel,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_row,
  input logic [7:0] out_col,
  input logic [2:0] status,
  input logic       last_flag
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
      && $stable(status) && $stable(last_flag))
    else $error("result changed while stalled");

  // Only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= 3'(ST_NONE)))
    else $error("undefined status code");

  // Enqueue results are always the final result of their transaction
  a_enq_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == 3'(ST_ADDED) || status == 3'(ST_MERGED)
      || status == 3'(ST_DROPPED)) |-> last_flag)
    else $error("enqueue result without last flag");

  // Nothing-pending result carries a zero tile and closes the transaction
  a_none_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == 3'(ST_NONE) |-> last_flag && out_row == 8'd0
      && out_col == 8'd0)
    else $error("malformed nothing-pending result");

endmodule

bind double_buffer_dirty_tile_queue dbdtq_chk u_chk (.*);
